@@ hdl/ntc_pkg.sv @@
// Package for the numeric type cast unit: type codes, per-stage payload structs
// and small decode functions. No dependencies.
package ntc_pkg;

    localparam logic [3:0] TY_F32 = 4'd0;
    localparam logic [3:0] TY_S8  = 4'd1;
    localparam logic [3:0] TY_S16 = 4'd2;
    localparam logic [3:0] TY_S32 = 4'd3;
    localparam logic [3:0] TY_S64 = 4'd4;
    localparam logic [3:0] TY_U8  = 4'd5;
    localparam logic [3:0] TY_U16 = 4'd6;
    localparam logic [3:0] TY_U32 = 4'd7;
    localparam logic [3:0] TY_U64 = 4'd8;

    localparam logic [0:0] REG_SOURCE = 1'b0;
    localparam logic [0:0] REG_TARGET = 1'b1;

    // Operation chosen in the first stage.
    localparam logic [1:0] OP_ZERO  = 2'd0;
    localparam logic [1:0] OP_PASS  = 2'd1;
    localparam logic [1:0] OP_F2I   = 2'd2;
    localparam logic [1:0] OP_I2F   = 2'd3;

    // Width in bits, encoded as log2(width) - 3: 0 -> 8, 3 -> 64.
    function automatic logic [1:0] type_wcode(input logic [3:0] ty);
        logic [1:0] r;
        begin
            case (ty)
                TY_S8, TY_U8:   r = 2'd0;
                TY_S16, TY_U16: r = 2'd1;
                TY_S64, TY_U64: r = 2'd3;
                default:        r = 2'd2;
            endcase
            return r;
        end
    endfunction

    function automatic logic type_is_signed(input logic [3:0] ty);
        return (ty == TY_S8) || (ty == TY_S16) || (ty == TY_S32) || (ty == TY_S64);
    endfunction

    function automatic logic [63:0] wmask(input logic [1:0] wc);
        logic [63:0] r;
        begin
            case (wc)
                2'd0:    r = 64'h0000_0000_0000_00FF;
                2'd1:    r = 64'h0000_0000_0000_FFFF;
                2'd2:    r = 64'h0000_0000_FFFF_FFFF;
                default: r = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            return r;
        end
    endfunction

    // Stage 1 -> stage 2 payload.
    typedef struct packed {
        logic [1:0]  op;
        logic        neg;
        logic [63:0] mag;     // magnitude (I2F), raw/extended value (PASS), float (F2I)
        logic [1:0]  twc;
        logic        tsgn;
        logic        last;
    } s1_t;

    // Stage 2 -> stage 3 payload.
    typedef struct packed {
        logic [1:0]  op;
        logic        neg;
        logic [63:0] val;     // shifted magnitude or passed bits
        logic [5:0]  p;       // leading one position (I2F)
        logic        sticky;  // I2F: bits below guard
        logic        over;    // F2I: overflow, infinity or NaN
        logic        nan;
        logic [1:0]  twc;
        logic        tsgn;
        logic        last;
    } s2_t;

    typedef struct packed {
        logic [63:0] bits;
        logic        sat;
        logic        last;
    } res_t;

endpackage

@@ hdl/ntc_decode.sv @@
// First stage of the numeric type cast unit: type decode, source masking and
// sign/magnitude split. Depends on ntc_pkg.
module ntc_decode
    import ntc_pkg::*;
(
    input  logic [3:0]  source_type,
    input  logic [3:0]  target_type,
    input  logic [63:0] in_bits,
    input  logic        in_last,
    output s1_t         s1
);

    logic [1:0]  swc;
    logic [63:0] smask;
    logic [63:0] raw;
    logic        neg;
    logic [5:0]  sw1;

    always_comb
    begin
        swc   = type_wcode(source_type);
        smask = wmask(swc);
        raw   = in_bits & smask;
        sw1   = 6'((7'd8 << swc) - 7'd1);
        neg   = type_is_signed(source_type) && raw[sw1];
        s1.neg  = 1'b0;
        s1.mag  = 64'd0;
        s1.twc  = type_wcode(target_type);
        s1.tsgn = type_is_signed(target_type);
        s1.last = in_last;
        s1.op   = OP_ZERO;
        if (source_type <= TY_U64 && target_type <= TY_U64) begin
            if (source_type == TY_F32) begin
                s1.mag = {32'd0, in_bits[31:0]};
                s1.op  = (target_type == TY_F32) ? OP_PASS : OP_F2I;
            end else if (target_type == TY_F32) begin
                s1.op  = OP_I2F;
                s1.neg = neg;
                s1.mag = neg ? ((~raw + 64'd1) & smask) : raw;
            end else begin
                s1.op  = OP_PASS;
                s1.mag = neg ? (raw | ~smask) : raw;
            end
        end
    end

endmodule

@@ hdl/ntc_align.sv @@
// Second stage: leading one search and alignment shift for integer to float,
// exponent decode and shift for float to integer. Depends on ntc_pkg.
module ntc_align
    import ntc_pkg::*;
(
    input  s1_t s1,
    output s2_t s2
);

    logic [5:0]  p;
    logic [7:0]  e;
    logic [5:0]  ex;
    logic [63:0] m;
    logic [5:0]  sh;
    logic [63:0] lowmask;

    always_comb
    begin
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (s1.mag[i]) begin
                p = 6'(i);
            end
        end
        e  = s1.mag[30:23];
        ex = 6'(e - 8'd127);
        m  = {40'd0, 1'b1, s1.mag[22:0]};
        sh = 6'd0;
        lowmask = 64'd0;

        s2.op     = s1.op;
        s2.neg    = s1.neg;
        s2.p      = p;
        s2.sticky = 1'b0;
        s2.over   = 1'b0;
        s2.nan    = 1'b0;
        s2.twc    = s1.twc;
        s2.tsgn   = s1.tsgn;
        s2.last   = s1.last;
        s2.val    = s1.mag;

        case (s1.op)
            OP_I2F:
            begin
                // Keep leading one plus 23 fraction bits, a guard bit, and sticky.
                if (p <= 6'd24) begin
                    s2.val = s1.mag << (6'd24 - p);
                end else begin
                    sh = p - 6'd24;
                    s2.val = s1.mag >> sh;
                    lowmask = ~(64'hFFFF_FFFF_FFFF_FFFF << sh);
                    s2.sticky = |(s1.mag & lowmask);
                end
            end
            OP_F2I:
            begin
                s2.neg = s1.mag[31];
                s2.nan = (e == 8'hFF) && (s1.mag[22:0] != 23'd0);
                s2.val = 64'd0;
                if (e == 8'hFF) begin
                    s2.over = 1'b1;
                end else if (e >= 8'd127) begin
                    if (e > 8'd190) begin
                        s2.over = 1'b1;
                    end else if (ex >= 6'd23) begin
                        s2.val = m << (ex - 6'd23);
                    end else begin
                        s2.val = m >> (6'd23 - ex);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ hdl/ntc_finish.sv @@
// Third stage: rounding and packing for integer to float, saturation for
// float to integer, target masking. Depends on ntc_pkg.
module ntc_finish
    import ntc_pkg::*;
(
    input  s2_t  s2,
    output res_t res
);

    logic [24:0] keep;
    logic        guard;
    logic        up;
    logic [7:0]  expo;
    logic [63:0] tmask;
    logic [63:0] lim;
    logic [63:0] slim;

    always_comb
    begin
        tmask = wmask(s2.twc);
        lim   = tmask;
        slim  = {1'b0, tmask[63:1]} + 64'd1;   // 2^(w-1)
        keep  = {1'b0, s2.val[24:1]};
        guard = s2.val[0];
        up    = guard && (s2.sticky || keep[0]);
        keep  = keep + {24'd0, up};
        expo  = 8'(s2.p) + 8'd127;
        res.bits = 64'd0;
        res.sat  = 1'b0;
        res.last = s2.last;
        case (s2.op)
            OP_PASS:
            begin
                res.bits = s2.val & tmask;
            end
            OP_I2F:
            begin
                if (s2.val != 64'd0 || s2.sticky) begin
                    if (keep[24]) begin
                        res.bits = {32'd0, s2.neg, expo + 8'd1, keep[23:1]};
                    end else begin
                        res.bits = {32'd0, s2.neg, expo, keep[22:0]};
                    end
                end
            end
            OP_F2I:
            begin
                if (s2.nan) begin
                    res.sat = 1'b1;
                end else if (!s2.tsgn) begin
                    if (s2.neg) begin
                        res.sat = s2.over || (s2.val != 64'd0);
                    end else if (s2.over || s2.val > lim) begin
                        res.sat  = 1'b1;
                        res.bits = lim;
                    end else begin
                        res.bits = s2.val;
                    end
                end else if (s2.neg) begin
                    if (s2.over || s2.val > slim) begin
                        res.sat  = 1'b1;
                        res.bits = (~slim + 64'd1) & tmask;
                    end else begin
                        res.bits = (~s2.val + 64'd1) & tmask;
                    end
                end else if (s2.over || s2.val > slim - 64'd1) begin
                    res.sat  = 1'b1;
                    res.bits = slim - 64'd1;
                end else begin
                    res.bits = s2.val;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ hdl/numeric_type_cast_unit.sv @@
// Numeric type cast unit: float32 and 8..64-bit integer conversions.
// An accepted request passes through the decode, align and finish stages to out_valid.
// Throughput: one request per cycle; the pipeline advances whenever its
// output register is empty or being taken.
// Reset (rst_n, async, active low) empties the pipeline and clears both type registers.
// Depends on ntc_pkg, ntc_decode, ntc_align, ntc_finish.
module numeric_type_cast_unit
    import ntc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] in_bits,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_bits,
    output logic        out_saturated,
    output logic        out_last
);

    // The one-bit index sends every write to one of the two registers. The user must
    // see that the types are only changed while the pipeline is empty; unchecked here.
    logic [3:0] source_type_reg;
    logic [3:0] target_type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            source_type_reg <= TY_F32;
            target_type_reg <= TY_F32;
        end else if (cfg_we) begin
            if (cfg_index == REG_SOURCE) begin
                source_type_reg <= cfg_data;
            end else begin
                target_type_reg <= cfg_data;
            end
        end
    end

    // The whole pipeline moves as one when the last stage can drain. Since every
    // stage holds when the output is stalled, nothing is lost or repeated.
    logic advance;
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    s1_t  s1_comb;
    s2_t  s2_comb;
    res_t res_comb;

    s1_t  s1_reg;
    s2_t  s2_reg;
    res_t res_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    ntc_decode u_decode (
        .source_type (source_type_reg),
        .target_type (target_type_reg),
        .in_bits     (in_bits),
        .in_last     (in_last),
        .s1          (s1_comb)
    );

    ntc_align u_align (
        .s1 (s1_reg),
        .s2 (s2_comb)
    );

    ntc_finish u_finish (
        .s2  (s2_reg),
        .res (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            s1_reg  <= s1_comb;
            s2_reg  <= s2_comb;
            res_reg <= res_comb;
        end
    end

    assign out_valid     = v3_reg;
    assign out_bits      = res_reg.bits;
    assign out_saturated = res_reg.sat;
    assign out_last      = res_reg.last;

endmodule

@@ hdl/ntc_checker.sv @@
// Port-level checker for the numeric type cast unit, bound to the top level.
// Depends on numeric_type_cast_unit's ports only.
module ntc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] out_bits,
    input logic        out_saturated
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_bits))
        else $error("stalled result changed");

    // The input is stalled only while the output is stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // A request accepted with a free pipe comes out when no output stall holds it on the way.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("result missing after pipeline latency");

    // A saturation flag on a stalled valid result holds.
    a_sat_int: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_saturated && out_stall |=> out_saturated)
        else $error("saturation flag dropped while stalled");

endmodule

bind numeric_type_cast_unit ntc_checker u_ntc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bits      (out_bits),
    .out_saturated (out_saturated)
);

@@ bench/tb_numeric_type_cast_unit.sv @@
// Self-checking bench for the numeric type cast unit: directed and random
// conversions between all type codes, with random idle and stall phases.
// Depends on ntc_pkg and the numeric_type_cast_unit RTL.
module tb_numeric_type_cast_unit
    import ntc_pkg::*;
;

    typedef struct {
        logic [63:0] bits;
        logic        sat;
        logic        last;
    } cast_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] in_bits;
    logic        in_last;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] out_bits;
    logic        out_saturated;
    logic        out_last;

    // Our own copy of the two type registers.
    logic [3:0]   src_ty;
    logic [3:0]   dst_ty;
    cast_result_t pending_casts[$];
    int           error_count;
    int           idle_pct;
    int           stall_pct;

    numeric_type_cast_unit uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_bits(in_bits), .in_last(in_last), .out_valid(out_valid),
        .out_stall(out_stall), .out_bits(out_bits),
        .out_saturated(out_saturated), .out_last(out_last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int bit_width(input logic [3:0] ty);
        case (ty)
            TY_S8, TY_U8:   return 8;
            TY_S16, TY_U16: return 16;
            TY_S64, TY_U64: return 64;
            default:        return 32;
        endcase
    endfunction

    function automatic logic [63:0] low_mask(input int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic is_signed_ty(input logic [3:0] ty);
        return ty == TY_S8 || ty == TY_S16 || ty == TY_S32 || ty == TY_S64;
    endfunction

    // Integer magnitude to float32 bits, round to nearest with ties to even.
    function automatic logic [63:0] int_to_single(input logic neg, input logic [63:0] mag);
        int          lead;
        int          sh;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] expo;
        if (mag == 0)
            return 64'd0;
        lead = 0;
        for (int i = 0; i < 64; i++)
            if (mag[i])
                lead = i;
        expo = 64'(lead + 127);
        if (lead <= 23)
        begin
            keep = mag << (23 - lead);
        end
        else
        begin
            sh = lead - 23;
            keep = mag >> sh;
            rem = mag & low_mask(sh);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0]))
                keep++;
            if (keep >> 24 != 0)
            begin
                keep >>= 1;
                expo++;
            end
        end
        return (64'(neg) << 31) | (expo << 23) | (keep & 64'h7F_FFFF);
    endfunction

    // Float32 to integer, truncating toward zero; saturation raises the flag.
    function automatic logic [63:0] single_to_int(input logic [31:0] f, input int w,
                                                  input logic sgn, output logic sat);
        logic        neg;
        logic [7:0]  e;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] lim;
        logic        over;
        neg = f[31];
        e = f[30:23];
        frac = {41'd0, f[22:0]};
        mag = 0;
        over = 1'b0;
        sat = 1'b0;
        if (e == 8'hFF && frac != 0)
        begin
            sat = 1'b1;
            return 64'd0;
        end
        if (e == 8'hFF)
            over = 1'b1;
        else if (e >= 127)
        begin
            if (e - 127 > 63)
                over = 1'b1;
            else if (e - 127 >= 23)
                mag = (frac | 64'h80_0000) << (e - 127 - 23);
            else
                mag = (frac | 64'h80_0000) >> (23 - (e - 127));
        end
        if (!sgn)
        begin
            lim = low_mask(w);
            if (neg)
            begin
                sat = over || mag != 0;
                return 64'd0;
            end
            if (over || mag > lim)
            begin
                sat = 1'b1;
                return lim;
            end
            return mag;
        end
        lim = 64'd1 << (w - 1);
        if (neg)
        begin
            if (over || mag > lim)
            begin
                sat = 1'b1;
                mag = lim;
            end
            return (~mag + 64'd1) & low_mask(w);
        end
        if (over || mag > lim - 1)
        begin
            sat = 1'b1;
            return lim - 1;
        end
        return mag;
    endfunction

    function automatic cast_result_t predict_cast(input logic [63:0] raw_in,
                                                  input logic last);
        cast_result_t r;
        int           sw;
        int           tw;
        logic [63:0]  raw;
        logic         neg;
        r.bits = 0;
        r.sat = 1'b0;
        r.last = last;
        if (src_ty <= TY_U64 && dst_ty <= TY_U64)
        begin
            sw = bit_width(src_ty);
            tw = bit_width(dst_ty);
            raw = raw_in & low_mask(sw);
            if (src_ty == TY_F32)
            begin
                if (dst_ty == TY_F32)
                    r.bits = raw;
                else
                    r.bits = single_to_int(raw[31:0], tw, is_signed_ty(dst_ty), r.sat);
            end
            else
            begin
                neg = is_signed_ty(src_ty) && raw[sw - 1];
                if (dst_ty == TY_F32)
                    r.bits = int_to_single(neg, neg ? ((~raw + 1) & low_mask(sw)) : raw);
                else
                    r.bits = (neg ? (raw | ~low_mask(sw)) : raw) & low_mask(tw);
            end
        end
        return r;
    endfunction

    // Sends one request, holding it until the unit takes it. The valid stays
    // high afterwards so that requests can follow back to back; idling and
    // the type writes drop it.
    task automatic send_request(input logic [63:0] bits, input logic last);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_bits <= bits;
        in_last <= last;
        pending_casts.push_back(predict_cast(bits, last));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Waits for the pipeline to drain, then writes both type registers.
    task automatic set_types(input logic [3:0] s, input logic [3:0] d);
        in_valid <= 1'b0;
        while (pending_casts.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_SOURCE;
        cfg_data <= s;
        @(posedge clk);
        cfg_index <= REG_TARGET;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        src_ty = s;
        dst_ty = d;
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        cast_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_casts.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got bits %h", $time, out_bits);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_casts.pop_front();
                    if (out_bits !== exp_r.bits || out_saturated !== exp_r.sat ||
                        out_last !== exp_r.last)
                    begin
                        $display("%0t: expected bits %h sat %b last %b, got %h %b %b",
                                 $time, exp_r.bits, exp_r.sat, exp_r.last,
                                 out_bits, out_saturated, out_last);
                        error_count++;
                    end
                end
            end
            out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Float patterns near the interesting edges: zero, sub-one, limits, inf, NaN.
    function automatic logic [63:0] rand_single();
        logic [31:0] f;
        f = $urandom();
        case ($urandom_range(5))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'($urandom_range(0, 126));
            2: f[30:23] = 8'($urandom_range(127, 127 + 66));
            default: f[30:23] = 8'($urandom_range(120, 200));
        endcase
        return {$urandom(), f};
    endfunction

    // Directed corners: field extremes, every pair of codes 0..8, pairs with code 15, and the float specials.
    task automatic test_directed();
        logic [63:0] corners[10];
        corners = '{64'd0, '1, 64'h7F, 64'h80, 64'h7F80_0000, 64'hFF80_0000,
                    64'h7FC0_0001, 64'h3F00_0000, 64'hDF00_0000, 64'h0100_0001};
        for (int s = 0; s < 16; s++)
        begin
            for (int d = 0; d < 16; d++)
            begin
                if ((s > 8 || d > 8) && !(s == 15 || d == 15))
                    continue;
                set_types(4'(s), 4'(d));
                for (int k = 0; k < 10; k++)
                    send_request(corners[k], k[0]);
            end
        end
    endtask

    task automatic test_random_casts(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
                set_types(4'($urandom_range(99) < 5 ? $urandom_range(9, 15)
                                                    : $urandom_range(8)),
                          4'($urandom_range(99) < 5 ? $urandom_range(9, 15)
                                                    : $urandom_range(8)));
            send_request(src_ty == TY_F32 ? rand_single() : rand64(),
                         1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SOURCE;
        cfg_data = '0;
        in_valid = 1'b0;
        in_bits = '0;
        in_last = 1'b0;
        out_stall = 1'b0;
        src_ty = TY_F32;
        dst_ty = TY_F32;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_casts(70);
        idle_pct = 56;
        test_random_casts(70);
        idle_pct = 0;
        stall_pct = 56;
        test_random_casts(70);
        idle_pct = 6;
        stall_pct = 6;
        test_random_casts(70);
        in_valid <= 1'b0;
        while (pending_casts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ numeric_type_cast_unit.f @@
hdl/ntc_pkg.sv
hdl/ntc_decode.sv
hdl/ntc_align.sv
hdl/ntc_finish.sv
hdl/numeric_type_cast_unit.sv
hdl/ntc_checker.sv
bench/tb_numeric_type_cast_unit.sv
